@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the beat detector RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EBD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define EBD_ASSERT(lbl, clk, rstn, prop, msg)
`define EBD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ hdl/ebd_pkg.sv @@
// ----------------------------------------------------------------------------
// ebd_pkg
// Widths, constants and types of the energy beat detector.
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam int DEF_HISTORY_DEPTH = 512;

    localparam int MAG_W     = 16;
    localparam int FTIME_W   = 16;
    localparam int ENERGY_W  = 25;
    localparam int INTENS_W  = 16;
    localparam int BRATIO_W  = 12;
    localparam int FADE_W    = 16;
    localparam int DPROD_W   = FADE_W + FTIME_W;
    localparam int DEC_SHIFT = 8;
    localparam int DEC_W     = DPROD_W - DEC_SHIFT;
    localparam int CMP_SHIFT = 8;
    localparam int ONE_SHIFT = 16;

    localparam logic [ENERGY_W-1:0] ENERGY_ONE     = ENERGY_W'(1) << ONE_SHIFT;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX     = '1;
    localparam logic [INTENS_W-1:0] INTENSITY_FULL = '1;

    localparam logic [BRATIO_W-1:0] BEAT_RATIO_RST = BRATIO_W'(358);
    localparam logic [FADE_W-1:0]   FADE_RATE_RST  = FADE_W'(1024);

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        REG_BEAT_RATIO = 1'b0,
        REG_FADE_RATE  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] instant_energy;
        logic [INTENS_W-1:0] intensity;
        logic                beat_detected;
    } result_t;

endpackage

@@ hdl/ebd_ram.sv @@
// ----------------------------------------------------------------------------
// ebd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ebd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/energy_beat_detector.sv @@
// ----------------------------------------------------------------------------
// energy_beat_detector
// Sums spectrum bins into frame energy and flags beats against a history.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  s_*       | in        | one bin: magnitude, frame time, tlast ends the frame
//  m_*       | out       | one per frame: beat flag, intensity, instant energy
//  APB       | in        | beat_ratio at 0x0, fade_rate at 0x4
//
//  One bin word per cycle while s_tready is high. A frame result is queued
//  through history RAM read, multiply, then compare, and shows on m_* once
//  earlier results have left. A 4-word output queue; s_tready drops while 4
//  results are outstanding. No clearing pass after reset: never-written
//  history slots read as 1.0 through the fill position.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module energy_beat_detector
    import ebd_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [15:0] bin_magnitude, [31:16] frame_time
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] beat_detected, [16:1] intensity,
                                            // [41:17] instant_energy
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = ENERGY_W + SLOT_W;
    localparam int CMP_W  = BRATIO_W + SUM_W;
    localparam int PROD_W = ENERGY_W + FILL_W;

    // configuration
    logic [BRATIO_W-1:0] beat_ratio_reg;
    logic [FADE_W-1:0]   fade_rate_reg;
    reg_idx_t            reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_BEAT_RATIO: prdata = APB_DW'(beat_ratio_reg);
            REG_FADE_RATE:  prdata = APB_DW'(fade_rate_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_ratio_reg <= BEAT_RATIO_RST;
            fade_rate_reg  <= FADE_RATE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BEAT_RATIO: beat_ratio_reg <= pwdata[BRATIO_W-1:0];
                REG_FADE_RATE:  fade_rate_reg  <= pwdata[FADE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage A: accumulate, pick history slot, issue RAM read
    logic [MAG_W-1:0]    mag;
    logic [FTIME_W-1:0]  ftime;
    logic                s_acc;
    logic                frame_end;
    logic [ENERGY_W:0]   acc_sum;
    logic [ENERGY_W-1:0] instant_a;
    logic                in_fill;
    logic [SLOT_W-1:0]   slot_a;
    logic                dflt_a;
    logic [DPROD_W-1:0]  dec_prod;

    logic [ENERGY_W-1:0] acc_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [SLOT_W-1:0]   oldest_reg;
    logic                tail_written_reg;
    logic [CNT_W-1:0]    pending_reg;
    logic [CNT_W-1:0]    pending_next;

    assign mag       = s_tdata[MAG_W-1:0];
    assign ftime     = s_tdata[MAG_W +: FTIME_W];
    assign s_tready  = pending_reg < CNT_W'(OUT_DEPTH);
    assign s_acc     = s_tvalid && s_tready;
    assign frame_end = s_acc && s_tlast;
    assign acc_sum   = {1'b0, acc_reg} + (ENERGY_W + 1)'(mag);
    assign instant_a = acc_sum[ENERGY_W] ? ENERGY_MAX : acc_sum[ENERGY_W-1:0];
    assign in_fill   = fill_reg < FILL_W'(HISTORY_DEPTH);
    assign slot_a    = in_fill ? SLOT_W'(fill_reg - 1'b1) : oldest_reg;
    // slots never written read as 1.0
    assign dflt_a    = in_fill ||
                       (slot_a == SLOT_W'(HISTORY_DEPTH - 1) && !tail_written_reg);
    assign dec_prod  = DPROD_W'(fade_rate_reg) * DPROD_W'(ftime);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg          <= '0;
            fill_reg         <= FILL_W'(1);
            oldest_reg       <= '0;
            tail_written_reg <= 1'b0;
        end else if (s_acc) begin
            acc_reg <= s_tlast ? '0 : instant_a;
            if (s_tlast) begin
                if (in_fill) begin
                    fill_reg <= fill_reg + 1'b1;
                end else begin
                    if (oldest_reg == SLOT_W'(HISTORY_DEPTH - 1)) begin
                        oldest_reg       <= '0;
                        tail_written_reg <= 1'b1;
                    end else begin
                        oldest_reg <= oldest_reg + 1'b1;
                    end
                end
            end
        end
    end

    // stage B: old slot value, running sum, products
    logic                b_valid_reg;
    logic [ENERGY_W-1:0] b_instant_reg;
    logic [FILL_W-1:0]   b_fill_reg;
    logic [SLOT_W-1:0]   b_slot_reg;
    logic                b_dflt_reg;
    logic [DEC_W-1:0]    b_dec_reg;

    logic                fwd_valid_reg;
    logic [SLOT_W-1:0]   fwd_slot_reg;
    logic [ENERGY_W-1:0] fwd_data_reg;

    logic [ENERGY_W-1:0] hist_rdata;
    logic [ENERGY_W-1:0] old_b;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]   lhs_prod;
    logic [CMP_W-1:0]    rhs_prod;

    ebd_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_slot_reg),
        .wr_data (b_instant_reg),
        .rd_addr (slot_a),
        .rd_data (hist_rdata)
    );

    always_comb begin
        priority if (fwd_valid_reg && fwd_slot_reg == b_slot_reg) begin
            old_b = fwd_data_reg;
        end else if (b_dflt_reg) begin
            old_b = ENERGY_ONE;
        end else begin
            old_b = hist_rdata;
        end
    end

    assign sum_next = sum_reg - SUM_W'(old_b) + SUM_W'(b_instant_reg);
    assign lhs_prod = PROD_W'(b_instant_reg) * PROD_W'(b_fill_reg);
    assign rhs_prod = CMP_W'(beat_ratio_reg) * CMP_W'(sum_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            sum_reg       <= SUM_W'(HISTORY_DEPTH) << ONE_SHIFT;
        end else begin
            b_valid_reg   <= frame_end;
            fwd_valid_reg <= b_valid_reg;
            if (b_valid_reg) begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b_instant_reg <= instant_a;
        b_fill_reg    <= fill_reg;
        b_slot_reg    <= slot_a;
        b_dflt_reg    <= dflt_a;
        b_dec_reg     <= dec_prod[DPROD_W-1:DEC_SHIFT];
        fwd_slot_reg  <= b_slot_reg;
        fwd_data_reg  <= b_instant_reg;
    end

    // stage C: compare, intensity update, push result
    logic                c_valid_reg;
    logic [CMP_W-1:0]    c_lhs_reg;
    logic [CMP_W-1:0]    c_rhs_reg;
    logic [DEC_W-1:0]    c_dec_reg;
    logic [ENERGY_W-1:0] c_instant_reg;
    logic                c_beat;
    logic [INTENS_W-1:0] intensity_reg;
    logic [INTENS_W-1:0] intensity_next;

    assign c_beat = c_lhs_reg > c_rhs_reg;

    always_comb begin
        priority if (c_beat) begin
            intensity_next = INTENSITY_FULL;
        end else if (c_dec_reg >= DEC_W'(intensity_reg)) begin
            intensity_next = '0;
        end else begin
            intensity_next = intensity_reg - c_dec_reg[INTENS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg   <= 1'b0;
            intensity_reg <= '0;
        end else begin
            c_valid_reg <= b_valid_reg;
            if (c_valid_reg) begin
                intensity_reg <= intensity_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        c_lhs_reg     <= CMP_W'({lhs_prod, CMP_SHIFT'(0)});
        c_rhs_reg     <= rhs_prod;
        c_dec_reg     <= b_dec_reg;
        c_instant_reg <= b_instant_reg;
    end

    // output queue
    result_t          fifo_mem_reg [OUT_DEPTH];
    result_t          push_word;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign push_word.instant_energy = c_instant_reg;
    assign push_word.intensity      = intensity_next;
    assign push_word.beat_detected  = c_beat;

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = M_TDATA_W'(fifo_mem_reg[rd_ptr_reg]);
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (frame_end && !pop) begin
            pending_next = pending_reg + 1'b1;
        end else if (pop && !frame_end) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
            if (c_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (c_valid_reg && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !c_valid_reg) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg) begin
            fifo_mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    `EBD_ASSERT(a_pending_bound, aclk, aresetn, pending_reg <= CNT_W'(OUT_DEPTH), "pending count overrun")
    `EBD_ASSERT_NEVER(a_queue_overflow, aclk, aresetn, c_valid_reg && count_reg == CNT_W'(OUT_DEPTH), "push into full output queue")
    `EBD_ASSERT(a_frame_latency, aclk, aresetn, frame_end |-> ##2 c_valid_reg, "frame result missing in stage C")
    `EBD_ASSERT(a_beat_full, aclk, aresetn, (c_valid_reg && c_beat) |=> intensity_reg == INTENSITY_FULL, "beat without full intensity")
    `EBD_ASSERT_NEVER(a_fill_range, aclk, aresetn, fill_reg == '0 || fill_reg > FILL_W'(HISTORY_DEPTH), "fill position out of range")

endmodule

@@ tb/sv/tb_energy_beat_detector.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_energy_beat_detector
// Streams spectrum frames into the beat detector and checks each frame result
// against a cycle-free model of the energy history, the beat compare and the
// intensity decay. A directed table comes first, then random frames through
// history fill, wrap-around, an all-silent history and accumulator saturation,
// with random idling on both sides and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_energy_beat_detector;
    import ebd_pkg::*;

    localparam int HIST_DEPTH   = DEF_HISTORY_DEPTH;
    localparam int RES_W        = $bits(result_t);
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_ROWS       = 19;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [MAG_W-1:0]  mag;
        logic              last;
        logic [FTIME_W-1:0] ft;
        bit                known;
        result_t           res;
        reg_idx_t          reg_sel;
        logic [APB_DW-1:0] val;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [15:0] bin_magnitude, [31:16] frame_time
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [0] beat_detected, [16:1] intensity,
                                     // [41:17] instant_energy
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // detector model state
    logic [ENERGY_W-1:0] hist_energy [HIST_DEPTH];
    logic [63:0]         hist_sum;
    int unsigned         fill_pos;
    int unsigned         oldest_pos;
    logic [INTENS_W-1:0] intens_now;
    logic [ENERGY_W-1:0] frame_acc;
    logic [BRATIO_W-1:0] ratio_reg;
    logic [FADE_W-1:0]   fade_reg;

    result_t  pending_results [$];
    dir_row_t stim_rows [N_ROWS];

    int fail_count   = 0;
    int stall_cycles = 0;
    bit idle_on      = 1'b1;
    bit gaps_on      = 1'b1;
    bit hold_out     = 1'b0;

    energy_beat_detector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 40) begin
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    // accumulate one bin; on the last bin run the beat compare and history update
    function automatic void advance_detector(input logic [MAG_W-1:0] mag, input logic last,
            input logic [FTIME_W-1:0] ft, output bit produced, output result_t res);
        logic [ENERGY_W:0]   total;
        logic [ENERGY_W-1:0] energy;
        logic [63:0]         lhs;
        logic [63:0]         rhs;
        logic [63:0]         dec;
        int unsigned         slot;
        bit                  beat;
        total    = frame_acc + mag;
        energy   = (total > ENERGY_MAX) ? ENERGY_MAX : total[ENERGY_W-1:0];
        produced = last;
        res      = '0;
        if (!last) begin
            frame_acc = energy;
            return;
        end
        frame_acc = '0;
        lhs  = (64'(energy) * 64'(fill_pos)) << CMP_SHIFT;
        rhs  = 64'(ratio_reg) * hist_sum;
        beat = lhs > rhs;
        if (beat) begin
            intens_now = INTENSITY_FULL;
        end else if (intens_now != '0) begin
            dec = (64'(fade_reg) * 64'(ft)) >> DEC_SHIFT;
            intens_now = (dec >= 64'(intens_now)) ? '0 : intens_now - INTENS_W'(dec);
        end
        if (fill_pos < HIST_DEPTH) begin
            slot = fill_pos - 1;
            fill_pos++;
        end else begin
            slot = oldest_pos;
            oldest_pos = (oldest_pos + 1) % HIST_DEPTH;
        end
        hist_sum = hist_sum - 64'(hist_energy[slot]) + 64'(energy);
        hist_energy[slot] = energy;
        res.beat_detected  = beat;
        res.intensity      = intens_now;
        res.instant_energy = energy;
    endfunction

    task automatic send_word(input logic [MAG_W-1:0] mag, input logic last,
                             input logic [FTIME_W-1:0] ft, input bit use_known,
                             input result_t known);
        bit      produced;
        result_t res;
        if (idle_on && gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ft, mag};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        advance_detector(mag, last, ft, produced, res);
        if (produced) begin
            pending_results.push_back(use_known ? known : res);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // read back a register; leaves the APB port idle
    task automatic check_register(input reg_idx_t idx);
        logic [APB_DW-1:0] want;
        want    = (idx == REG_BEAT_RATIO) ? APB_DW'(ratio_reg) : APB_DW'(fade_reg);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            report_mismatch("register readback", prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(input reg_idx_t idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_BEAT_RATIO: ratio_reg = val[BRATIO_W-1:0];
            REG_FADE_RATE:  fade_reg  = val[FADE_W-1:0];
        endcase
        check_register(idx);
    endtask

    task automatic run_frames(input int n_frames, input int hold_at);
        int               n_bins;
        int               style;
        logic [MAG_W-1:0] mag;
        logic [FTIME_W-1:0] ft;
        for (int f = 0; f < n_frames; f++) begin
            if (f == hold_at) begin
                hold_out = 1'b1;
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n_bins = 1;
                6, 7, 8:          n_bins = $urandom_range(2, 4);
                default:          n_bins = $urandom_range(5, 24);
            endcase
            style = $urandom_range(0, 3);
            for (int b = 0; b < n_bins; b++) begin
                case (style)
                    0:       mag = $urandom_range(0, 15);
                    1:       mag = $urandom_range(0, 16383);
                    2:       mag = $urandom_range(32768, 65535);
                    default: mag = $urandom_range(0, 65535);
                endcase
                ft = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 511);
                send_word(mag, b == n_bins - 1, ft, 1'b0, '0);
            end
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_out) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_out = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", got.instant_energy, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.beat_detected !== want.beat_detected)
                    report_mismatch("beat_detected", got.beat_detected, want.beat_detected);
                if (got.intensity !== want.intensity)
                    report_mismatch("intensity", got.intensity, want.intensity);
                if (got.instant_energy !== want.instant_energy)
                    report_mismatch("instant_energy", got.instant_energy,
                                    want.instant_energy);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_energy_beat_detector failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        foreach (hist_energy[i]) hist_energy[i] = ENERGY_ONE;
        hist_sum   = 64'(HIST_DEPTH) * 64'(ENERGY_ONE);
        fill_pos   = 1;
        oldest_pos = 0;
        intens_now = '0;
        frame_acc  = '0;
        ratio_reg  = BEAT_RATIO_RST;
        fade_reg   = FADE_RATE_RST;

        //             kind      mag       last  ft        known  {energy, intensity, beat}
        stim_rows = '{
            '{ROW_WORD, 16'h0000, 1'b1, 16'h0000, 1'b1, {25'd0, 16'h0000, 1'b0},
              REG_BEAT_RATIO, 32'd0},
            '{ROW_WORD, 16'hFFFF, 1'b0, 16'hFFFF, 1'b0, '0, REG_BEAT_RATIO, 32'd0},
            '{ROW_WORD, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, '0, REG_BEAT_RATIO, 32'd0},
            '{ROW_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, '0, REG_BEAT_RATIO, 32'd0},
            '{ROW_WORD, 16'h0001, 1'b1, 16'h0000, 1'b1, {25'd1, 16'hFFFF, 1'b1},
              REG_BEAT_RATIO, 32'd0},
            '{ROW_WORD, 16'h0000, 1'b1, 16'h0000, 1'b1, {25'd0, 16'hFFFF, 1'b0},
              REG_BEAT_RATIO, 32'd0},
            '{ROW_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, '0, REG_FADE_RATE, 32'd65535},
            '{ROW_WORD, 16'h0000, 1'b1, 16'hFFFF, 1'b1, {25'd0, 16'h0000, 1'b0},
              REG_BEAT_RATIO, 32'd0},
            '{ROW_WORD, 16'hFFFF, 1'b1, 16'h0000, 1'b1, {25'd65535, 16'hFFFF, 1'b1},
              REG_BEAT_RATIO, 32'd0},
            '{ROW_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, '0, REG_FADE_RATE, 32'd0},
            '{ROW_WORD, 16'h0000, 1'b1, 16'hFFFF, 1'b1, {25'd0, 16'hFFFF, 1'b0},
              REG_BEAT_RATIO, 32'd0},
            '{ROW_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, '0, REG_FADE_RATE, 32'd1},
            '{ROW_WORD, 16'h0000, 1'b1, 16'hFFFF, 1'b0, '0, REG_BEAT_RATIO, 32'd0},
            '{ROW_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, '0, REG_BEAT_RATIO, 32'd4095},
            '{ROW_WORD, 16'h8000, 1'b0, 16'h5555, 1'b0, '0, REG_BEAT_RATIO, 32'd0},
            '{ROW_WORD, 16'h7FFF, 1'b0, 16'hAAAA, 1'b0, '0, REG_BEAT_RATIO, 32'd0},
            '{ROW_WORD, 16'hFFFF, 1'b1, 16'h00FF, 1'b0, '0, REG_BEAT_RATIO, 32'd0},
            '{ROW_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, '0, REG_BEAT_RATIO, 32'd358},
            '{ROW_CFG,  16'h0000, 1'b0, 16'h0000, 1'b0, '0, REG_FADE_RATE, 32'd1024}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_register(REG_BEAT_RATIO);
        check_register(REG_FADE_RATE);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG) begin
                wait_idle();
                set_register(stim_rows[i].reg_sel, stim_rows[i].val);
            end else begin
                send_word(stim_rows[i].mag, stim_rows[i].last, stim_rows[i].ft,
                          stim_rows[i].known, stim_rows[i].res);
            end
        end

        // fill the history; output held off for a while early on
        run_frames(520, 100);

        wait_idle();
        set_register(REG_BEAT_RATIO, 32'd4095);
        set_register(REG_FADE_RATE, 32'd65535);
        run_frames(60, -1);

        // silent frames until every history slot is zero
        wait_idle();
        set_register(REG_BEAT_RATIO, 32'd358);
        set_register(REG_FADE_RATE, 32'd1024);
        for (int i = 0; i < HIST_DEPTH; i++) begin
            send_word('0, 1'b1, $urandom_range(0, 65535), 1'b0, '0);
        end
        send_word('0, 1'b1, 16'hFFFF, 1'b0, '0);
        send_word(16'd1, 1'b1, 16'h0000, 1'b0, '0);
        run_frames(40, -1);

        wait_idle();
        set_register(REG_BEAT_RATIO, 32'd256);
        set_register(REG_FADE_RATE, $urandom_range(0, 65535));
        run_frames(150, -1);

        wait_idle();
        set_register(REG_BEAT_RATIO, $urandom_range(0, 4095));
        set_register(REG_FADE_RATE, $urandom_range(0, 65535));
        run_frames(100, -1);

        // long frame that saturates the accumulator
        for (int i = 0; i < 520; i++) begin
            send_word(16'hFFFF, 1'b0, $urandom_range(0, 65535), 1'b0, '0);
        end
        send_word(16'hFFFF, 1'b1, $urandom_range(0, 65535), 1'b0, '0);

        idle_on = 1'b0;
        run_frames(60, -1);

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_energy_beat_detector passed");
        end else begin
            $display("tb_energy_beat_detector failed");
        end
        $finish;
    end

endmodule
